[hw/rtl/rsb_pkg.sv]
// ----------------------------------------------------------------------------
// rsb_pkg
// shared constants, codes and types of the rotate / scale RGB565 blitter
// ----------------------------------------------------------------------------
`default_nettype none

package rsb_pkg;

  // source image geometry and scale limit
  localparam int SIDE      = 96;
  localparam int MAX_SCALE = 6;

  // field widths
  localparam int CFG_W     = 12;
  localparam int SCALE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int COMP_W    = 8;
  localparam int IN_W      = 3 * COMP_W;
  localparam int ADDR_W    = 24;
  localparam int COLOR_W   = 16;
  localparam int OUT_W     = ADDR_W + COLOR_W;
  localparam int USER_W    = 2;
  localparam int POS_W     = $clog2(SIDE);
  localparam int PROD_W    = POS_W + SCALE_W;
  localparam int SHOWN_W   = $clog2(SIDE * (2 ** SCALE_W));

  // register reset values
  localparam logic [CFG_W-1:0]   WIDTH_RST  = CFG_W'(320);
  localparam logic [CFG_W-1:0]   HEIGHT_RST = CFG_W'(240);
  localparam logic [CFG_W-1:0]   STRIDE_RST = CFG_W'(320);
  localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(1);

  // tuser bit positions on the result side
  localparam int USER_FRAME_DONE = 0;
  localparam int USER_CFG_ERROR  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ROW_STRIDE   = 2'd2,
    CFG_SCALE_FACTOR = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_EMIT,
    ST_ERR
  } rsb_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // input beat taken
    logic calc;   // block origin terms
    logic mul;    // start address product
    logic beat;   // result beat taken during a run
  } rsb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cfg_ok;   // current registers form a usable setup
    logic run_end;  // the shown beat is the last of its item
  } rsb_status_t;

  function automatic logic [COLOR_W-1:0] pack565(input logic [IN_W-1:0] rgb);
    logic [COMP_W-1:0] r, g, b;
    r = rgb[COMP_W-1:0];
    g = rgb[2*COMP_W-1:COMP_W];
    b = rgb[3*COMP_W-1:2*COMP_W];
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rotate_scale_blit_rgb565_unit.sv]
// ----------------------------------------------------------------------------
// rotate_scale_blit_rgb565_unit
// rotates a square RGB888 source a quarter turn anticlockwise, packs it to
// RGB565, upscales by an integer factor and centres it in a framebuffer
// ----------------------------------------------------------------------------
//
//  channel   | direction | beat content
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | one source pixel, raster order, column fastest
//  m_axis    | out       | one framebuffer write, or one error beat per pixel
//  cfg       | in        | register write: width, height, stride, scale
//
//  a pixel first forms the block origin, then the start address product, then
//  gives one write beat per cycle from the address counter while the output
//  does not stall; the next pixel is taken on the last beat
//  a pixel under an invalid setup gives a single error beat
//  output stalls hold the shown beat; the input waits until the run ends
//  reset returns the registers to 320 x 240, stride 320, scale 1, and the
//  source position to the top-left pixel
//
`default_nettype none

module rotate_scale_blit_rgb565_unit import rsb_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // source pixels
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [IN_W-1:0]      s_axis_tdata,   // red, green, blue
  // framebuffer writes
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata,   // write_address, pixel_color
  output logic                      m_axis_tlast,   // last_of_run
  output logic [USER_W-1:0]         m_axis_tuser,   // frame_done, config_error
  // register writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  rsb_cmd_t    cmd;
  rsb_status_t status;

  // sequencer: owns both handshakes
  rsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // registers, position tracking and address generation
  rsb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

[hw/rtl/rsb_ctrl.sv]
// ----------------------------------------------------------------------------
// rsb_ctrl
// sequencer of the blitter: accept, origin, product, write run or error beat
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_ctrl import rsb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  input  wire rsb_status_t status_i,
  output rsb_cmd_t         cmd_o
);

  rsb_state_e state_q, state_d;
  logic       free;

  // free to take an input: idle, or the final beat of the current item leaves now
  assign free = (state_q == ST_IDLE) ||
                (((state_q == ST_EMIT) || (state_q == ST_ERR)) &&
                 m_tready_i && status_i.run_end);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = status_i.cfg_ok ? ST_CALC : ST_ERR;
      end
      ST_CALC: state_d = ST_MUL;
      ST_MUL:  state_d = ST_EMIT;
      ST_EMIT, ST_ERR: begin
        if (m_tready_i && status_i.run_end) begin
          if (s_tvalid_i) state_d = status_i.cfg_ok ? ST_CALC : ST_ERR;
          else            state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o = free;
    m_tvalid_o = (state_q == ST_EMIT) || (state_q == ST_ERR);
    cmd_o.load = free && s_tvalid_i;
    cmd_o.calc = (state_q == ST_CALC);
    cmd_o.mul  = (state_q == ST_MUL);
    cmd_o.beat = (state_q == ST_EMIT) && m_tready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rsb_dp.sv]
// ----------------------------------------------------------------------------
// rsb_dp
// datapath: registers, source position, origin and address generation
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_dp import rsb_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic [IN_W-1:0]      s_tdata_i,
  input  wire rsb_cmd_t             cmd_i,
  output rsb_status_t               status_o,
  output logic [OUT_W-1:0]          m_tdata_o,
  output logic                      m_tlast_o,
  output logic [USER_W-1:0]         m_tuser_o
);

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SIDE - 1);

  logic [CFG_W-1:0]   width_q, height_q, stride_q;
  logic [SCALE_W-1:0] scale_q;
  logic [POS_W-1:0]   col_pos_q, row_pos_q;

  // per-item registers
  logic [SCALE_W-1:0] it_scale_q;
  logic [CFG_W-1:0]   it_stride_q, ox_q, oy_q, row0_q, col0_q;
  logic [POS_W-1:0]   rx_q, ry_q;
  logic [COLOR_W-1:0] color_q;
  logic               last_px_q, err_q;
  logic [SCALE_W-1:0] dx_q, dy_q;
  logic [ADDR_W-1:0]  line_q, addr_q;

  logic [SHOWN_W-1:0] shown;
  logic [CFG_W-1:0]   shown_x;
  logic               cfg_ok, dx_last, dy_last;
  logic [PROD_W-1:0]  prod_y, prod_x;

  assign shown   = SHOWN_W'(SHOWN_W'(SIDE) * SHOWN_W'(scale_q));
  assign shown_x = CFG_W'(shown);
  assign cfg_ok  = (scale_q != '0) && (scale_q <= SCALE_W'(MAX_SCALE)) &&
                   (stride_q >= width_q) && (shown_x <= width_q) &&
                   (shown_x <= height_q);

  assign prod_y = PROD_W'(ry_q) * PROD_W'(it_scale_q);
  assign prod_x = PROD_W'(rx_q) * PROD_W'(it_scale_q);

  assign dx_last = (dx_q == it_scale_q - SCALE_W'(1));
  assign dy_last = (dy_q == it_scale_q - SCALE_W'(1));

  assign status_o.cfg_ok  = cfg_ok;
  assign status_o.run_end = err_q || (dx_last && dy_last);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      stride_q <= STRIDE_RST;
      scale_q  <= SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        CFG_ROW_STRIDE:   stride_q <= cfg_data_i;
        CFG_SCALE_FACTOR: scale_q  <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // source position, raster order, moves only on a usable setup
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
    end else if (cmd_i.load && cfg_ok) begin
      if (col_pos_q >= POS_LAST) begin
        col_pos_q <= '0;
        row_pos_q <= (row_pos_q >= POS_LAST) ? '0 : row_pos_q + POS_W'(1);
      end else begin
        col_pos_q <= col_pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else if (cmd_i.load) begin
      err_q <= !cfg_ok;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      color_q     <= pack565(s_tdata_i);
      it_scale_q  <= scale_q;
      it_stride_q <= stride_q;
      ox_q        <= (width_q - shown_x) >> 1;
      oy_q        <= (height_q - shown_x) >> 1;
      rx_q        <= row_pos_q;
      ry_q        <= POS_LAST - col_pos_q;
      last_px_q   <= (col_pos_q == POS_LAST) && (row_pos_q == POS_LAST);
    end
    if (cmd_i.calc) begin
      row0_q <= oy_q + CFG_W'(prod_y);
      col0_q <= ox_q + CFG_W'(prod_x);
      dx_q   <= '0;
      dy_q   <= '0;
    end
    if (cmd_i.mul) begin
      line_q <= ADDR_W'(row0_q) * ADDR_W'(it_stride_q) + ADDR_W'(col0_q);
      addr_q <= ADDR_W'(row0_q) * ADDR_W'(it_stride_q) + ADDR_W'(col0_q);
    end
    if (cmd_i.beat) begin
      if (dx_last) begin
        dx_q   <= '0;
        dy_q   <= dy_q + SCALE_W'(1);
        line_q <= line_q + ADDR_W'(it_stride_q);
        addr_q <= line_q + ADDR_W'(it_stride_q);
      end else begin
        dx_q   <= dx_q + SCALE_W'(1);
        addr_q <= addr_q + ADDR_W'(1);
      end
    end
  end

  assign m_tdata_o = err_q ? '0 : {color_q, addr_q};
  assign m_tlast_o = !err_q && dx_last && dy_last;
  assign m_tuser_o[USER_FRAME_DONE] = !err_q && dx_last && dy_last && last_px_q;
  assign m_tuser_o[USER_CFG_ERROR]  = err_q;

endmodule

`default_nettype wire

[hw/rtl/rsb_chk.sv]
// ----------------------------------------------------------------------------
// rsb_chk
// port-level checks of the blitter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_chk import rsb_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [OUT_W-1:0]   m_axis_tdata,
  input wire logic               m_axis_tlast,
  input wire logic [USER_W-1:0]  m_axis_tuser
);

  // an error beat carries no write
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[USER_CFG_ERROR] |->
      !m_axis_tlast && !m_axis_tuser[USER_FRAME_DONE] && (m_axis_tdata == '0))
    else $error("error beat carries write data");

  // end of frame only on the last write of a run
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[USER_FRAME_DONE] |-> m_axis_tlast)
    else $error("frame end off a run end");

  // a run continues the next cycle with the same colour
  a_run_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast && !m_axis_tuser[USER_CFG_ERROR]
    |=> m_axis_tvalid &&
        (m_axis_tdata[OUT_W-1:ADDR_W] == $past(m_axis_tdata[OUT_W-1:ADDR_W])))
    else $error("run broken or colour changed");

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled beat changed");

endmodule

bind rotate_scale_blit_rgb565_unit rsb_chk u_rsb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
